>>> rtl/core/complex_arithmetic_unit_top_macros.svh
// Assertion macros for the complex arithmetic unit.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cau_pkg.sv
// Shared types, constants and saturation helper for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TOL_WIDTH   = 16;
    localparam int OP_WIDTH    = 3;
    localparam int PROD_W      = 2 * DATA_WIDTH;
    localparam int SUM_W       = PROD_W + 1;
    localparam int SAT_IN_W    = SUM_W + 1;
    localparam int REM_W       = 3 * DATA_WIDTH;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

    localparam logic [OP_WIDTH-1:0] OP_ADD  = OP_WIDTH'(0);
    localparam logic [OP_WIDTH-1:0] OP_SUB  = OP_WIDTH'(1);
    localparam logic [OP_WIDTH-1:0] OP_MUL  = OP_WIDTH'(2);
    localparam logic [OP_WIDTH-1:0] OP_DIV  = OP_WIDTH'(3);
    localparam logic [OP_WIDTH-1:0] OP_EQ   = OP_WIDTH'(4);
    localparam logic [OP_WIDTH-1:0] OP_CONJ = OP_WIDTH'(5);
    localparam logic [OP_WIDTH-1:0] OP_MOD  = OP_WIDTH'(6);

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(DATA_MAX);
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic [OP_WIDTH-1:0] operation;
        data_t               a_re;
        data_t               a_im;
        data_t               b_re;
        data_t               b_im;
    } cau_in_t;

    typedef struct packed {
        data_t res_re;
        data_t res_im;
        logic  is_equal;
        logic  div_by_zero;
        logic  saturated;
    } cau_out_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV,
        KIND_MOD
    } kind_t;

    typedef struct packed {
        kind_t    kind;
        data_t    a_re;
        data_t    a_im;
        data_t    b_re;
        data_t    b_im;
        cau_out_t simple;
    } cau_rec_t;

    typedef struct packed {
        data_t value;
        logic  clamped;
    } sat_t;

    function automatic sat_t saturate(input logic signed [SAT_IN_W-1:0] v);
        sat_t r;
        r.value   = v[DATA_WIDTH-1:0];
        r.clamped = 1'b0;
        if (v < SAT_MIN)
        begin
            r.value   = DATA_MIN;
            r.clamped = 1'b1;
        end
        else if (v > SAT_MAX)
        begin
            r.value   = DATA_MAX;
            r.clamped = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/cau_front.sv
// Front end: accepts command words, classifies them and finishes the cheap opcodes.
// Depends on cau_pkg.
module cau_front
    import cau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cau_in_t              operands,
    input  logic [TOL_WIDTH-1:0] tolerance,
    input  logic                 queue_full,
    output logic                 push,
    output cau_rec_t             rec
);

    logic                        fv_reg;
    logic                        fv_next;
    cau_rec_t                    rec_reg;
    cau_rec_t                    rec_next;
    logic                        accept;
    logic signed [DATA_WIDTH:0]  sum_re;
    logic signed [DATA_WIDTH:0]  sum_im;
    logic signed [DATA_WIDTH:0]  dif_re;
    logic signed [DATA_WIDTH:0]  dif_im;
    logic signed [DATA_WIDTH:0]  neg_im;
    logic [DATA_WIDTH:0]         mag_re;
    logic [DATA_WIDTH:0]         mag_im;
    sat_t                        s_re;
    sat_t                        s_im;

    assign busy   = fv_reg && queue_full;
    assign accept = start && !busy;
    assign push   = fv_reg && !queue_full;
    assign rec    = rec_reg;
    // hold the word while the queue is full
    assign fv_next = accept || (fv_reg && queue_full);

    always_comb
    begin
        sum_re = (DATA_WIDTH+1)'(operands.a_re) + (DATA_WIDTH+1)'(operands.b_re);
        sum_im = (DATA_WIDTH+1)'(operands.a_im) + (DATA_WIDTH+1)'(operands.b_im);
        dif_re = (DATA_WIDTH+1)'(operands.a_re) - (DATA_WIDTH+1)'(operands.b_re);
        dif_im = (DATA_WIDTH+1)'(operands.a_im) - (DATA_WIDTH+1)'(operands.b_im);
        neg_im = -(DATA_WIDTH+1)'(operands.a_im);
        mag_re = dif_re[DATA_WIDTH] ? $unsigned(-dif_re) : $unsigned(dif_re);
        mag_im = dif_im[DATA_WIDTH] ? $unsigned(-dif_im) : $unsigned(dif_im);
        s_re   = '0;
        s_im   = '0;

        rec_next.kind   = KIND_SIMPLE;
        rec_next.a_re   = operands.a_re;
        rec_next.a_im   = operands.a_im;
        rec_next.b_re   = operands.b_re;
        rec_next.b_im   = operands.b_im;
        rec_next.simple = '0;

        unique case (operands.operation)
            OP_ADD:
            begin
                s_re = saturate(SAT_IN_W'(sum_re));
                s_im = saturate(SAT_IN_W'(sum_im));
            end
            OP_SUB:
            begin
                s_re = saturate(SAT_IN_W'(dif_re));
                s_im = saturate(SAT_IN_W'(dif_im));
            end
            OP_CONJ:
            begin
                s_re = saturate(SAT_IN_W'(operands.a_re));
                s_im = saturate(SAT_IN_W'(neg_im));
            end
            OP_EQ:
            begin
                rec_next.simple.is_equal = (mag_re < (DATA_WIDTH+1)'(tolerance))
                                        && (mag_im < (DATA_WIDTH+1)'(tolerance));
            end
            OP_MUL:  rec_next.kind = KIND_MUL;
            OP_DIV:  rec_next.kind = KIND_DIV;
            OP_MOD:  rec_next.kind = KIND_MOD;
            default: rec_next.kind = KIND_SIMPLE;
        endcase

        rec_next.simple.res_re    = s_re.value;
        rec_next.simple.res_im    = s_im.value;
        rec_next.simple.saturated = s_re.clamped || s_im.clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= fv_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rec_reg <= rec_next;
    end

endmodule

>>> rtl/core/cau_queue.sv
// Short register queue between the front end and the arithmetic back end.
// Depends on cau_pkg.
module cau_queue
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cau_rec_t wr_rec,
    input  logic     pop,
    output cau_rec_t rd_rec,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cau_rec_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_rec  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (PTR_W+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

>>> rtl/core/cau_back.sv
// Back end: pipelined products, sums, restoring divide and square root, final saturation.
// Depends on cau_pkg.
module cau_back
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  cau_rec_t in_rec,
    output logic     done,
    output cau_out_t result
);

    localparam int W = DATA_WIDTH;
    localparam int F = FRAC_BITS;

    typedef struct packed {
        kind_t    kind;
        cau_out_t simple;
    } tag_t;

    typedef struct packed {
        tag_t tag;
        sat_t mul_re;
        sat_t mul_im;
        logic neg_re;
        logic neg_im;
        logic dz;
    } mid_t;

    function automatic sat_t div_fix(input logic neg, input logic ovf,
                                     input logic [W-1:0] q);
        sat_t r;
        r.clamped = 1'b0;
        r.value   = neg ? data_t'(~q + W'(1)) : data_t'(q);
        if (neg && (ovf || q > $unsigned(DATA_MIN)))
        begin
            r.value   = DATA_MIN;
            r.clamped = 1'b1;
        end
        else if (!neg && (ovf || q[W-1]))
        begin
            r.value   = DATA_MAX;
            r.clamped = 1'b1;
        end
        return r;
    endfunction

    // stage 1: products
    logic                     v1_reg;
    tag_t                     tag1_reg;
    logic signed [PROD_W-1:0] m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    // stage 2: sums
    logic                     v2_reg;
    tag_t                     tag2_reg;
    logic signed [SUM_W-1:0]  re_sum_reg, im_sum_reg;
    logic [PROD_W-1:0]        den2_reg;
    // stage 3: magnitudes, multiply result
    logic                     v3_reg;
    mid_t                     mid3_reg;
    mid_t                     mid3_next;
    logic [REM_W-1:0]         n_re3_reg, n_im3_reg;
    logic [PROD_W-1:0]        den3_reg, sq3_reg;
    logic [SUM_W-1:0]         mag_re, mag_im;
    logic signed [SUM_W-1:0]  sh_re, sh_im;
    // divide / root chain, index 0 is the overflow check stage
    logic                     v_reg    [W+1];
    mid_t                     mid_reg  [W+1];
    logic [1:0]               ovf_reg  [W+1];
    logic [REM_W-1:0]         rem_re_reg [W+1];
    logic [REM_W-1:0]         rem_im_reg [W+1];
    logic [PROD_W-1:0]        den_reg  [W+1];
    logic [W-1:0]             q_re_reg [W+1];
    logic [W-1:0]             q_im_reg [W+1];
    logic [PROD_W-1:0]        srem_reg [W+1];
    logic [W-1:0]             root_reg [W+1];
    // output
    logic                     done_reg;
    cau_out_t                 out_reg;
    cau_out_t                 out_next;
    sat_t                     f_re, f_im;

    assign done   = done_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i <= W; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v_reg[0] <= v3_reg;
            for (int i = 0; i < W; i++)
                v_reg[i+1] <= v_reg[i];
            done_reg <= v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg.kind   <= in_rec.kind;
        tag1_reg.simple <= in_rec.simple;
        // modulus reuses the first two multipliers as squarers
        m1_reg <= in_rec.a_re * ((in_rec.kind == KIND_MOD) ? in_rec.a_re : in_rec.b_re);
        m2_reg <= in_rec.a_im * ((in_rec.kind == KIND_MOD) ? in_rec.a_im : in_rec.b_im);
        m3_reg <= in_rec.a_re * in_rec.b_im;
        m4_reg <= in_rec.a_im * in_rec.b_re;
        m5_reg <= in_rec.b_re * in_rec.b_re;
        m6_reg <= in_rec.b_im * in_rec.b_im;

        tag2_reg <= tag1_reg;
        if (tag1_reg.kind == KIND_MUL)
        begin
            re_sum_reg <= SUM_W'(m1_reg) - SUM_W'(m2_reg);
            im_sum_reg <= SUM_W'(m3_reg) + SUM_W'(m4_reg);
        end
        else
        begin
            re_sum_reg <= SUM_W'(m1_reg) + SUM_W'(m2_reg);
            im_sum_reg <= SUM_W'(m4_reg) - SUM_W'(m3_reg);
        end
        den2_reg <= $unsigned(m5_reg) + $unsigned(m6_reg);
    end

    always_comb
    begin
        sh_re  = re_sum_reg >>> F;
        sh_im  = im_sum_reg >>> F;
        mag_re = re_sum_reg[SUM_W-1] ? $unsigned(-re_sum_reg) : $unsigned(re_sum_reg);
        mag_im = im_sum_reg[SUM_W-1] ? $unsigned(-im_sum_reg) : $unsigned(im_sum_reg);
        mid3_next.tag    = tag2_reg;
        mid3_next.mul_re = saturate(SAT_IN_W'(sh_re));
        mid3_next.mul_im = saturate(SAT_IN_W'(sh_im));
        mid3_next.neg_re = re_sum_reg[SUM_W-1];
        mid3_next.neg_im = im_sum_reg[SUM_W-1];
        mid3_next.dz     = den2_reg == '0;
    end

    always_ff @(posedge clk)
    begin
        mid3_reg  <= mid3_next;
        n_re3_reg <= REM_W'(mag_re) << F;
        n_im3_reg <= REM_W'(mag_im) << F;
        den3_reg  <= den2_reg;
        sq3_reg   <= re_sum_reg[PROD_W-1:0];

        // quotient of W bits or more saturates regardless of sign
        mid_reg[0]    <= mid3_reg;
        ovf_reg[0][1] <= n_re3_reg >= (REM_W'(den3_reg) << W);
        ovf_reg[0][0] <= n_im3_reg >= (REM_W'(den3_reg) << W);
        rem_re_reg[0] <= n_re3_reg;
        rem_im_reg[0] <= n_im3_reg;
        den_reg[0]    <= den3_reg;
        q_re_reg[0]   <= '0;
        q_im_reg[0]   <= '0;
        srem_reg[0]   <= sq3_reg;
        root_reg[0]   <= '0;
    end

    for (genvar k = 0; k < W; k++)
    begin : g_stage
        localparam int J = W - 1 - k;

        logic [REM_W-1:0]  trial_d;
        logic [PROD_W:0]   trial_s;
        logic [REM_W-1:0]  rem_re_next, rem_im_next;
        logic [W-1:0]      q_re_next, q_im_next;
        logic [PROD_W-1:0] srem_next;
        logic [W-1:0]      root_next;

        always_comb
        begin
            trial_d     = REM_W'(den_reg[k]) << J;
            trial_s     = ((PROD_W+1)'(root_reg[k]) << (J + 1))
                        + ((PROD_W+1)'(1) << (2 * J));
            rem_re_next = rem_re_reg[k];
            rem_im_next = rem_im_reg[k];
            q_re_next   = q_re_reg[k];
            q_im_next   = q_im_reg[k];
            srem_next   = srem_reg[k];
            root_next   = root_reg[k];
            if (rem_re_reg[k] >= trial_d)
            begin
                rem_re_next  = rem_re_reg[k] - trial_d;
                q_re_next[J] = 1'b1;
            end
            if (rem_im_reg[k] >= trial_d)
            begin
                rem_im_next  = rem_im_reg[k] - trial_d;
                q_im_next[J] = 1'b1;
            end
            if ({1'b0, srem_reg[k]} >= trial_s)
            begin
                srem_next    = srem_reg[k] - trial_s[PROD_W-1:0];
                root_next[J] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            mid_reg[k+1]    <= mid_reg[k];
            ovf_reg[k+1]    <= ovf_reg[k];
            den_reg[k+1]    <= den_reg[k];
            rem_re_reg[k+1] <= rem_re_next;
            rem_im_reg[k+1] <= rem_im_next;
            q_re_reg[k+1]   <= q_re_next;
            q_im_reg[k+1]   <= q_im_next;
            srem_reg[k+1]   <= srem_next;
            root_reg[k+1]   <= root_next;
        end
    end

    always_comb
    begin
        out_next = '0;
        f_re     = '0;
        f_im     = '0;
        unique case (mid_reg[W].tag.kind)
            KIND_SIMPLE:
                out_next = mid_reg[W].tag.simple;
            KIND_MUL:
            begin
                f_re = mid_reg[W].mul_re;
                f_im = mid_reg[W].mul_im;
            end
            KIND_DIV:
            begin
                if (mid_reg[W].dz)
                    out_next.div_by_zero = 1'b1;
                else
                begin
                    f_re = div_fix(mid_reg[W].neg_re, ovf_reg[W][1], q_re_reg[W]);
                    f_im = div_fix(mid_reg[W].neg_im, ovf_reg[W][0], q_im_reg[W]);
                end
            end
            KIND_MOD:
            begin
                f_re.value   = root_reg[W][W-1] ? DATA_MAX : data_t'(root_reg[W]);
                f_re.clamped = root_reg[W][W-1];
            end
            default:
                out_next = '0;
        endcase
        if (mid_reg[W].tag.kind != KIND_SIMPLE)
        begin
            out_next.res_re    = f_re.value;
            out_next.res_im    = f_im.value;
            out_next.saturated = f_re.clamped || f_im.clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

>>> rtl/core/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: front end, queue, back end, tolerance register.
// Depends on cau_pkg, cau_front, cau_queue, cau_back and the assertion macro header.
//
//  channel   | handshake         | word
//  ----------+-------------------+-----------------------------------------------
//  command   | start / busy      | operands: operation, a_re, a_im, b_re, b_im
//  result    | done (one cycle)  | result: res_re, res_im, is_equal, div_by_zero,
//            |                   |         saturated
//  config    | cfg_we            | cfg_data: equal_tolerance
//
// One command word per cycle is taken while busy is low; every word runs the same
// pipeline, so results leave in order; the pipeline depth is set by the one-bit-per-stage
// divide and square-root chain.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the tolerance to 1.
// The result side cannot stall; busy rises only if the queue fills, which a
// fixed-rate back end never lets happen in steady flow.
`include "complex_arithmetic_unit_top_macros.svh"

module complex_arithmetic_unit_top
    import cau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cau_in_t              operands,
    output logic                 done,
    output cau_out_t             result,
    input  logic                 cfg_we,
    input  logic [TOL_WIDTH-1:0] cfg_data
);

    logic [TOL_WIDTH-1:0] tol_reg;
    logic                 push;
    cau_rec_t             front_rec;
    cau_rec_t             queue_rec;
    logic                 queue_full;
    logic                 queue_empty;

    // tolerance register; the user must write it only while the unit is idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_we)
            tol_reg <= cfg_data;
    end

    // classify and finish add, sub, conjugate and equality up front
    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operands   (operands),
        .tolerance  (tol_reg),
        .queue_full (queue_full),
        .push       (push),
        .rec        (front_rec)
    );

    // decouple the front end from the arithmetic pipeline
    cau_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (front_rec),
        .pop    (!queue_empty),
        .rd_rec (queue_rec),
        .full   (queue_full),
        .empty  (queue_empty)
    );

    // drain one word per cycle into the fixed-latency back end
    cau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!queue_empty),
        .in_rec   (queue_rec),
        .done     (done),
        .result   (result)
    );

    `CAU_ASSERT_IMPL(a_flags_exclusive, done, $onehot0({result.is_equal, result.div_by_zero, result.saturated}), "result flags collide")
    `CAU_ASSERT_IMPL(a_dz_zeroes, done && result.div_by_zero, result.res_re == '0 && result.res_im == '0, "zero divisor with nonzero result")
    `CAU_ASSERT_IMPL(a_busy_full, busy, queue_full, "busy raised while queue has room")
    `CAU_ASSERT_NEXT(a_no_done_after_reset, !rst_n, !done, "result strobe right after reset")

endmodule

>>> tb/complex_arithmetic_unit_checker.sv
// Result checker for the complex arithmetic unit: predicts each result from the
// accepted command words and compares it with the result words. Depends on cau_pkg.
`timescale 1ns / 1ps

module complex_arithmetic_unit_checker
    import cau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  cau_in_t              operands,
    input  logic                 done,
    input  cau_out_t             result,
    input  logic                 cfg_we,
    input  logic [TOL_WIDTH-1:0] cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    typedef logic signed [127:0] wide_t;

    logic [TOL_WIDTH-1:0] tolerance;
    cau_out_t             pending_results[$];

    function automatic data_t clamp(input wide_t v, inout logic flag);
        wide_t hi;
        wide_t lo;
        hi = wide_t'(DATA_MAX);
        lo = wide_t'(DATA_MIN);
        if (v < lo)
        begin
            flag = 1'b1;
            return DATA_MIN;
        end
        if (v > hi)
        begin
            flag = 1'b1;
            return DATA_MAX;
        end
        return data_t'(v);
    endfunction

    function automatic cau_out_t alu_result(input cau_in_t w, input logic [TOL_WIDTH-1:0] tol);
        cau_out_t    r;
        wide_t       ar;
        wide_t       ai;
        wide_t       br;
        wide_t       bi;
        wide_t       den;
        wide_t       dr;
        wide_t       di;
        logic [127:0] s;
        logic [63:0]  root;
        logic [63:0]  c;
        ar = wide_t'(w.a_re);
        ai = wide_t'(w.a_im);
        br = wide_t'(w.b_re);
        bi = wide_t'(w.b_im);
        r  = '0;
        case (w.operation)
            OP_ADD:
            begin
                r.res_re = clamp(ar + br, r.saturated);
                r.res_im = clamp(ai + bi, r.saturated);
            end
            OP_SUB:
            begin
                r.res_re = clamp(ar - br, r.saturated);
                r.res_im = clamp(ai - bi, r.saturated);
            end
            OP_MUL:
            begin
                r.res_re = clamp((ar * br - ai * bi) >>> FRAC_BITS, r.saturated);
                r.res_im = clamp((ar * bi + ai * br) >>> FRAC_BITS, r.saturated);
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.div_by_zero = 1'b1;
                else
                begin
                    // signed division truncates toward zero, as the unit does
                    r.res_re = clamp(((ar * br + ai * bi) <<< FRAC_BITS) / den, r.saturated);
                    r.res_im = clamp(((ai * br - ar * bi) <<< FRAC_BITS) / den, r.saturated);
                end
            end
            OP_EQ:
            begin
                dr = ar - br;
                di = ai - bi;
                if (dr < 0) dr = -dr;
                if (di < 0) di = -di;
                r.is_equal = (dr < wide_t'(tol)) && (di < wide_t'(tol));
            end
            OP_CONJ:
            begin
                r.res_re = clamp(ar, r.saturated);
                r.res_im = clamp(-ai, r.saturated);
            end
            OP_MOD:
            begin
                s    = ar * ar + ai * ai;
                root = '0;
                for (int i = 32; i >= 0; i--)
                begin
                    c = root | (64'd1 << i);
                    if ({64'd0, c} * {64'd0, c} <= s)
                        root = c;
                end
                r.res_re = clamp(wide_t'({64'd0, root}), r.saturated);
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    assign outstanding = pending_results.size();

    always_ff @(posedge clk or negedge rst_n)
    begin
        cau_out_t want;
        if (!rst_n)
        begin
            tolerance = TOL_RESET;
            pending_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                tolerance = cfg_data;
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no command pending");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.res_re !== want.res_re)
                    begin
                        $error("res_re: expected %0d, got %0d", want.res_re, result.res_re);
                        mismatches++;
                    end
                    if (result.res_im !== want.res_im)
                    begin
                        $error("res_im: expected %0d, got %0d", want.res_im, result.res_im);
                        mismatches++;
                    end
                    if (result.is_equal !== want.is_equal)
                    begin
                        $error("is_equal: expected %0b, got %0b", want.is_equal,
                            result.is_equal);
                        mismatches++;
                    end
                    if (result.div_by_zero !== want.div_by_zero)
                    begin
                        $error("div_by_zero: expected %0b, got %0b", want.div_by_zero,
                            result.div_by_zero);
                        mismatches++;
                    end
                    if (result.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b", want.saturated,
                            result.saturated);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(alu_result(operands, tolerance));
        end
    end

endmodule

>>> tb/complex_arithmetic_unit_top_tb.sv
// Top of the complex arithmetic unit testbench: clock, reset, stimulus and verdict.
// Depends on cau_pkg, complex_arithmetic_unit_top and complex_arithmetic_unit_checker.
`timescale 1ns / 1ps

module complex_arithmetic_unit_top_tb;
    import cau_pkg::*;

    // Opcode 7 has no name in the package; the unit must answer with all zeros.
    localparam logic [OP_WIDTH-1:0] OP_UNUSED = OP_WIDTH'(7);
    // Wait added in drain after the checker has no results pending.
    localparam int DRAIN_CYCLES  = DATA_WIDTH + 20;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_WORDS   = 305;
    localparam int PHASES        = 6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    cau_in_t              operands = '0;
    logic                 done;
    cau_out_t             result;
    logic                 cfg_we = 1'b0;
    logic [TOL_WIDTH-1:0] cfg_data = '0;
    int                   mismatches;
    int                   outstanding;
    int                   quiet_cycles = 0;
    logic [TOL_WIDTH-1:0] tol_now = TOL_RESET;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    complex_arithmetic_unit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    complex_arithmetic_unit_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operands    (operands),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog: count cycles in which neither a command nor a result word moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one command word and hold it until the unit takes it. Busy only
    // moves on a rising edge, so sample it at the falling edge before.
    task automatic send_word(input cau_in_t w);
        logic taken;
        operands <= w;
        start    <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Drop start for one cycle.
    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for the pipeline to drain, then let the trailing latency pass.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the tolerance register; only called with the pipeline empty.
    task automatic write_tolerance(input logic [TOL_WIDTH-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
        tol_now = v;
    endtask

    function automatic cau_in_t make_word(input logic [OP_WIDTH-1:0] op, input data_t ar,
                                          input data_t ai, input data_t br, input data_t bi);
        cau_in_t w;
        w.operation = op;
        w.a_re = ar;
        w.a_im = ai;
        w.b_re = br;
        w.b_im = bi;
        return w;
    endfunction

    // Mix of full-range, corner and small values so that products and
    // quotients land both inside and outside the Q16.16 range.
    function automatic data_t rand_part();
        case ($urandom_range(0, 5))
            0, 1: return data_t'($urandom);
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return DATA_MAX;
                    1: return DATA_MIN;
                    2: return '0;
                    3: return -1;
                    4: return 1;
                    default: return data_t'(32'sd1 <<< FRAC_BITS);
                endcase
            end
            3: return data_t'($urandom_range(0, 32'h1F_FFFF)) - data_t'(32'h10_0000);
            default: return data_t'($urandom_range(0, 32'h3FF_FFFF)) - data_t'(32'h200_0000);
        endcase
    endfunction

    // Offset by at most the tolerance plus two so the equality test sees both outcomes.
    function automatic data_t near(input data_t v);
        int span;
        span = int'(tol_now) + 2;
        return v + data_t'($urandom_range(0, 2 * span)) - data_t'(span);
    endfunction

    function automatic cau_in_t rand_word();
        cau_in_t w;
        w = make_word(OP_WIDTH'($urandom_range(0, 6)), rand_part(), rand_part(),
                      rand_part(), rand_part());
        if ($urandom_range(0, 49) == 0)
            w.operation = OP_UNUSED;
        if (w.operation == OP_EQ && $urandom_range(0, 9) < 6)
        begin
            w.b_re = near(w.a_re);
            w.b_im = near(w.a_im);
        end
        if (w.operation == OP_DIV && $urandom_range(0, 9) == 0)
        begin
            w.b_re = '0;
            w.b_im = '0;
        end
        return w;
    endfunction

    initial
    begin
        int idle_pct[PHASES];
        logic [TOL_WIDTH-1:0] tol_set[PHASES];
        cau_in_t directed[$];

        idle_pct = '{0, 69, 24, 0, 69, 24};
        tol_set  = '{16'd1, 16'd65535, 16'd0, 16'd300, 16'd1, 16'd7};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset tolerance: extremes, every opcode, corner cases.
        directed.push_back(make_word(OP_ADD, DATA_MAX, DATA_MAX, DATA_MAX, 1));
        directed.push_back(make_word(OP_ADD, DATA_MIN, DATA_MIN, -1, DATA_MIN));
        directed.push_back(make_word(OP_SUB, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN));
        directed.push_back(make_word(OP_SUB, 5, -5, 5, -5));
        directed.push_back(make_word(OP_MUL, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
        directed.push_back(make_word(OP_MUL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
        directed.push_back(make_word(OP_MUL, -1, 1, 1, 1));
        directed.push_back(make_word(OP_MUL, 32'sh0001_8000, -32'sh0002_0000, 3, -7));
        directed.push_back(make_word(OP_DIV, 32'sh0001_0000, 32'sh0001_0000, 0, 0));
        directed.push_back(make_word(OP_DIV, DATA_MAX, DATA_MIN, 1, 0));
        directed.push_back(make_word(OP_DIV, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
        directed.push_back(make_word(OP_DIV, -7, 3, 32'sh0002_0000, -32'sh0000_8000));
        directed.push_back(make_word(OP_EQ, 100, -100, 100, -100));
        directed.push_back(make_word(OP_EQ, 100, -100, 101, -100));
        directed.push_back(make_word(OP_EQ, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN));
        directed.push_back(make_word(OP_CONJ, DATA_MIN, DATA_MIN, 0, 0));
        directed.push_back(make_word(OP_CONJ, DATA_MAX, DATA_MAX, -1, -1));
        directed.push_back(make_word(OP_MOD, 32'sh0003_0000, 32'sh0004_0000, 0, 0));
        directed.push_back(make_word(OP_MOD, DATA_MAX, DATA_MAX, 0, 0));
        directed.push_back(make_word(OP_MOD, DATA_MIN, 0, 0, 0));
        directed.push_back(make_word(OP_MOD, 0, 0, 0, 0));
        directed.push_back(make_word(OP_UNUSED, DATA_MAX, DATA_MIN, -1, 1));
        foreach (directed[i])
            send_word(directed[i]);
        drain();

        // Zero tolerance must refuse even identical operands.
        write_tolerance(16'd0);
        send_word(make_word(OP_EQ, 42, 42, 42, 42));
        send_word(make_word(OP_EQ, 0, 0, 0, 0));
        drain();

        // Random phases, each with its own tolerance and idle rate; every
        // register change waits for the pipeline to empty.
        for (int p = 0; p < PHASES; p++)
        begin
            write_tolerance(tol_set[p]);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                while ($urandom_range(0, 99) < idle_pct[p])
                    idle_cycle();
                send_word(rand_word());
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
